// ----- sv/vwo_pkg.sv -----
// Shared types, constants and helpers for the voice waveform oscillator.
// No dependencies; imported by the interfaces and all modules of the block.
`timescale 1ns / 1ps
`default_nettype none

package vwo_pkg;

   localparam int PhaseW = 24;
   localparam int LfsrW  = 23;
   localparam int WaveW  = 12;
   localparam int FreqW  = 16;
   localparam int SelW   = 4;
   localparam int AddrW  = 5;
   localparam int DataW  = 32;

   localparam logic [PhaseW-1:0] SyncPoint = 24'h80_0000;
   localparam logic [LfsrW-1:0]  LfsrOnes  = 23'h7F_FFFF;
   localparam logic [WaveW-1:0]  WaveOnes  = 12'hFFF;

   localparam int NoiseClkBit = 19;
   localparam int LfsrTapLo   = 17;
   localparam int LfsrTapHi   = 22;

   localparam logic [2:0] RegFrequency  = 3'd0;
   localparam logic [2:0] RegPulseWidth = 3'd1;
   localparam logic [2:0] RegWaveSelect = 3'd2;
   localparam logic [2:0] RegTestBit    = 3'd3;
   localparam logic [2:0] RegSyncEnable = 3'd4;
   localparam logic [2:0] RegRingMod    = 3'd5;

   localparam int SelTriangle = 0;
   localparam int SelSaw      = 1;
   localparam int SelPulse    = 2;
   localparam int SelNoise    = 3;

   typedef struct packed {
      logic [FreqW-1:0] frequency;
      logic [WaveW-1:0] pulse_width;
      logic [SelW-1:0]  waveform_select;
      logic             test_bit;
      logic             sync_enable;
      logic             ring_mod_enable;
   } cfg_type;

   function automatic logic [WaveW-1:0] noise_bits(input logic [LfsrW-1:0] v);
      noise_bits = {v[20], v[18], v[14], v[11], v[9], v[5], v[2], v[0], 4'b0000};
   endfunction

endpackage

`default_nettype wire

// ----- sv/vwo_if.sv -----
// Valid/ready stream interfaces for the oscillator's tick and result channels.
// Depends on vwo_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vwo_req_if
   import vwo_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [PhaseW-1:0] master_phase;

   modport source (output valid, output master_phase, input ready);
   modport sink   (input valid, input master_phase, output ready);
endinterface

interface vwo_rsp_if
   import vwo_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [WaveW-1:0]  wave_out;
   logic [PhaseW-1:0] phase_out;

   modport source (output valid, output wave_out, output phase_out, input ready);
   modport sink   (input valid, input wave_out, input phase_out, output ready);
endinterface

`default_nettype wire

// ----- sv/vwo_csr.sv -----
// APB-style register file holding the oscillator configuration.
// Depends on vwo_pkg for the register codes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module vwo_csr
   import vwo_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [AddrW-1:0] csr_paddr,
   input  wire logic [DataW-1:0] csr_pwdata,
   output      logic [DataW-1:0] csr_prdata,
   output      logic             csr_pready,
   output      cfg_type          cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[AddrW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            RegFrequency:  cfg_in.frequency       = csr_pwdata[FreqW-1:0];
            RegPulseWidth: cfg_in.pulse_width     = csr_pwdata[WaveW-1:0];
            RegWaveSelect: cfg_in.waveform_select = csr_pwdata[SelW-1:0];
            RegTestBit:    cfg_in.test_bit        = csr_pwdata[0];
            RegSyncEnable: cfg_in.sync_enable     = csr_pwdata[0];
            RegRingMod:    cfg_in.ring_mod_enable = csr_pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         RegFrequency:  csr_prdata = {{(DataW-FreqW){1'b0}}, cfg_ff.frequency};
         RegPulseWidth: csr_prdata = {{(DataW-WaveW){1'b0}}, cfg_ff.pulse_width};
         RegWaveSelect: csr_prdata = {{(DataW-SelW){1'b0}}, cfg_ff.waveform_select};
         RegTestBit:    csr_prdata = {{(DataW-1){1'b0}}, cfg_ff.test_bit};
         RegSyncEnable: csr_prdata = {{(DataW-1){1'b0}}, cfg_ff.sync_enable};
         RegRingMod:    csr_prdata = {{(DataW-1){1'b0}}, cfg_ff.ring_mod_enable};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/vwo_core.sv -----
// Oscillator datapath: tick input register, phase/noise state, result register.
// Depends on vwo_pkg and the stream interfaces in vwo_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module vwo_core
   import vwo_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   vwo_req_if.sink      req_chan,
   vwo_rsp_if.source    rsp_chan
);

   logic              in_valid_ff, in_valid_in;
   logic [PhaseW-1:0] master_ff;
   logic              out_valid_ff, out_valid_in;
   logic [WaveW-1:0]  wave_ff;
   logic [PhaseW-1:0] phase_out_ff;

   logic [PhaseW-1:0] phase_ff, phase_in;
   logic [LfsrW-1:0]  lfsr_ff, lfsr_in;
   logic              bit19_ff;

   logic              req_xfer, rsp_xfer, advance, clear;
   logic [WaveW-1:0]  saw, tri_src, tri_wave, pulse, wave_in;
   logic              tri_inv;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_xfer ? 1'b0 : out_valid_ff);

   // phase, then noise, then waveform from the new state
   assign clear    = cfg.test_bit || (cfg.sync_enable && master_ff == SyncPoint);
   assign phase_in = clear ? '0 : phase_ff + PhaseW'(cfg.frequency);

   always_comb begin
      lfsr_in = lfsr_ff;
      if (cfg.test_bit) begin
         lfsr_in = LfsrOnes;
      end else if (!bit19_ff && phase_in[NoiseClkBit]) begin
         lfsr_in = {lfsr_ff[LfsrW-2:0], lfsr_ff[LfsrTapLo] ^ lfsr_ff[LfsrTapHi]};
      end
   end

   assign saw      = phase_in[PhaseW-1 -: WaveW];
   assign tri_inv  = saw[WaveW-1] ^ (cfg.ring_mod_enable && master_ff[PhaseW-1]);
   assign tri_src  = tri_inv ? ~saw : saw;
   assign tri_wave = {tri_src[WaveW-2:0], 1'b0};
   assign pulse    = (saw > cfg.pulse_width) ? WaveOnes : '0;

   always_comb begin
      wave_in = WaveOnes;
      if (cfg.waveform_select[SelSaw]) begin
         wave_in = wave_in & saw;
      end
      if (cfg.waveform_select[SelTriangle]) begin
         wave_in = wave_in & tri_wave;
      end
      if (cfg.waveform_select[SelPulse]) begin
         wave_in = wave_in & pulse;
      end
      if (cfg.waveform_select[SelNoise]) begin
         wave_in = wave_in & noise_bits(lfsr_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= '0;
         lfsr_ff      <= LfsrOnes;
         bit19_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            lfsr_ff  <= lfsr_in;
            bit19_ff <= phase_in[NoiseClkBit];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         master_ff <= req_chan.master_phase;
      end
      if (advance) begin
         wave_ff      <= wave_in;
         phase_out_ff <= phase_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.wave_out  = wave_ff;
   assign rsp_chan.phase_out = phase_out_ff;

   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("noise register reached all zeros");

   a_edge_track: assert property (@(posedge clock) disable iff (reset)
      bit19_ff == phase_ff[NoiseClkBit])
      else $error("noise clock history out of step with phase");

   a_test_preset: assert property (@(posedge clock) disable iff (reset)
      advance && cfg.test_bit |=> phase_ff == '0 && lfsr_ff == LfsrOnes)
      else $error("test did not clear phase and preset noise");

   a_phase_match: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> phase_out_ff == phase_ff)
      else $error("result phase differs from accumulator");

endmodule

`default_nettype wire

// ----- sv/voice_waveform_oscillator.sv -----
// Voice waveform oscillator: one tick per transfer; one tick per cycle unless
// the result channel stalls. The phase add, noise shift and waveform AND are
// combinational between the tick register and the result register.
// Synchronous reset clears the configuration and phase and presets the
// noise register to all ones; no result is pending after reset.
// Depends on vwo_pkg, vwo_if.sv, vwo_csr and vwo_core.
`timescale 1ns / 1ps
`default_nettype none

module voice_waveform_oscillator
   import vwo_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   vwo_req_if.sink               req_chan,
   vwo_rsp_if.source             rsp_chan,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [AddrW-1:0] csr_paddr,
   input  wire logic [DataW-1:0] csr_pwdata,
   output      logic [DataW-1:0] csr_prdata,
   output      logic             csr_pready
);

   cfg_type cfg;

   vwo_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   vwo_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
